/* hw/rtl/stack_register_vm_execute_unit_macros.svh */
// ----------------------------------------------------------------------------
// stack register vm execute unit assertion macros
// shared assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef STACK_REGISTER_VM_EXECUTE_UNIT_MACROS_SVH
`define STACK_REGISTER_VM_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define SRVM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srvm check failed");

// next-cycle implication
`define SRVM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srvm check failed");

`endif

/* hw/rtl/srvm_pkg.sv */
// ----------------------------------------------------------------------------
// srvm_pkg
// shared constants, codes and types of the stack register vm execute unit
// ----------------------------------------------------------------------------
`default_nettype none
package srvm_pkg;
	localparam int DATA_W      = 32;
	localparam int REG_COUNT   = 17;
	localparam int REG_AW      = $clog2(REG_COUNT);
	localparam int MEM_WORDS   = 256;
	localparam int MEM_AW      = $clog2(MEM_WORDS);
	localparam int STACK_DEPTH = 256;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = STK_AW + 1;
	localparam int PROG_DEPTH  = 4096;
	localparam int TGT_W       = $clog2(PROG_DEPTH);
	localparam int IDX_W       = 8;
	localparam int IN_W        = 104;
	localparam int OUT_W       = 72;

	localparam logic [IDX_W-1:0] R_FLAG = IDX_W'(4);
	localparam logic [IDX_W-1:0] R_REM  = IDX_W'(5);
	localparam logic [IDX_W-1:0] R_TOP  = IDX_W'(6);
	localparam logic [IDX_W-1:0] R_PC   = IDX_W'(8);

	typedef enum logic [1:0] {
		K_REG = 2'd0,
		K_MEM = 2'd1,
		K_IMM = 2'd2,
		K_ALT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		E_NONE  = 2'd0,
		E_DIV0  = 2'd1,
		E_OVER  = 2'd2,
		E_UNDER = 2'd3
	} err_t;

	typedef enum logic [4:0] {
		OP_MOV = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_PUSHF = 5'd3,
		OP_POPF = 5'd4, OP_CALL = 5'd5, OP_RET = 5'd6, OP_INC = 5'd7,
		OP_DEC = 5'd8, OP_ADD = 5'd9, OP_SUB = 5'd10, OP_MUL = 5'd11,
		OP_DIV = 5'd12, OP_MOD = 5'd13, OP_REM = 5'd14, OP_NOT = 5'd15,
		OP_OR = 5'd16, OP_AND = 5'd17, OP_XOR = 5'd18, OP_SHL = 5'd19,
		OP_SHR = 5'd20, OP_CMP = 5'd21, OP_JMP = 5'd22, OP_JE = 5'd23,
		OP_JNE = 5'd24, OP_JG = 5'd25, OP_JGE = 5'd26, OP_JL = 5'd27,
		OP_JLE = 5'd28, OP_PRN = 5'd29, OP_NOP0 = 5'd30, OP_NOP1 = 5'd31
	} op_t;
endpackage
`default_nettype wire

/* hw/rtl/stack_register_vm_execute_unit.sv */
// ----------------------------------------------------------------------------
// stack_register_vm_execute_unit
// executes one decoded instruction per transaction against registers,
// data memory and stack
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s_*      in   func dst_kind dst_index dst_imm          -
//               src_kind src_index src_imm target
// m_*      out  next_pc print_value error                print_valid
//
// each instruction steps through accept, operand fetch and execute
// the result is valid the cycle after execute, when the next transaction may be accepted
// div and mod with a nonzero divisor wait in a divide state for the bit-serial divider
// a result not taken holds the execute step until m_tready
// reset clears registers, memory valid bits and stack count at once
// ----------------------------------------------------------------------------
`default_nettype none
module stack_register_vm_execute_unit (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// func, dst_kind, dst_index, dst_imm, src_kind, src_index, src_imm, target
	input  wire logic [srvm_pkg::IN_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// next_pc, print_value, error
	output logic [srvm_pkg::OUT_W-1:0]    m_tdata,
	// print_valid
	output logic                          m_tuser
);
	import srvm_pkg::*;
	`include "stack_register_vm_execute_unit_macros.svh"

	typedef enum logic [1:0] {ST_IDLE, ST_OPND, ST_DIV, ST_EXEC} state_t;

	state_t state_q;

	logic [4:0]        func_q;
	logic [1:0]        dk_q, sk_q;
	logic [IDX_W-1:0]  di_q, si_q;
	logic [DATA_W-1:0] dimm_q, simm_q;
	logic [TGT_W-1:0]  tgt_q;

	logic [DATA_W-1:0] flag_q, remr_q, top_q, pc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] a_q, b_q;

	logic [DATA_W-1:0] rf_mem [REG_COUNT];
	logic              rf_vld_q [REG_COUNT];
	logic [DATA_W-1:0] dm_mem [MEM_WORDS];
	logic              dm_vld_q [MEM_WORDS];
	logic [DATA_W-1:0] stk_mem [STACK_DEPTH];

	logic [DATA_W-1:0] rfa_s1, rfb_s1, dma_s1, dmb_s1, stk_s1;
	logic              rfa_v_s1, rfb_v_s1, dma_v_s1, dmb_v_s1;

	logic              acc;
	logic [4:0]        in_func;
	logic [IDX_W-1:0]  in_di, in_si;
	logic [DATA_W-1:0] a_c, b_c;
	logic              div_start, div_done;
	logic [DATA_W-1:0] div_quot, div_rem, mag_a, mag_b;

	logic [DATA_W-1:0] flag_n, remr_n, top_n, pc_n, wval, res_pv;
	logic [CNT_W-1:0]  cnt_n;
	logic              wen, step, take, printed, stk_we, out_free;
	logic [1:0]        err;
	logic [DATA_W-1:0] stk_wval, qs, rs;

	assign acc     = s_tvalid && s_tready;
	assign in_func = s_tdata[4:0];
	assign in_di   = s_tdata[14:7];
	assign in_si   = s_tdata[56:49];
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	function automatic logic [DATA_W-1:0] opnd(
		input logic [1:0] kind, input logic [IDX_W-1:0] idx,
		input logic [DATA_W-1:0] imm, input logic [DATA_W-1:0] rfd, input logic rfv,
		input logic [DATA_W-1:0] dmd, input logic dmv,
		input logic [DATA_W-1:0] fl, input logic [DATA_W-1:0] rm,
		input logic [DATA_W-1:0] tp, input logic [DATA_W-1:0] pc);
		logic [DATA_W-1:0] v;
		v = imm;
		if (kind == K_REG) begin
			if (idx == R_FLAG)                    v = fl;
			else if (idx == R_REM)                v = rm;
			else if (idx == R_TOP)                v = tp;
			else if (idx == R_PC)                 v = pc;
			else if (idx < IDX_W'(REG_COUNT))     v = rfv ? rfd : '0;
			else                                  v = '0;
		end else if (kind == K_MEM) begin
			v = dmv ? dmd : '0;
		end
		return v;
	endfunction

	assign a_c = opnd(dk_q, di_q, dimm_q, rfa_s1, rfa_v_s1, dma_s1, dma_v_s1,
		flag_q, remr_q, top_q, pc_q);
	assign b_c = opnd(sk_q, si_q, simm_q, rfb_s1, rfb_v_s1, dmb_s1, dmb_v_s1,
		flag_q, remr_q, top_q, pc_q);

	assign mag_a = a_c[DATA_W-1] ? (DATA_W'(0) - a_c) : a_c;
	assign mag_b = b_c[DATA_W-1] ? (DATA_W'(0) - b_c) : b_c;
	assign div_start = (state_q == ST_OPND) && (b_c != '0) &&
		(func_q == OP_DIV || func_q == OP_MOD);

	srvm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_a),
		.divisor  (mag_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign qs = (a_q[DATA_W-1] != b_q[DATA_W-1]) ? (DATA_W'(0) - div_quot) : div_quot;
	assign rs = a_q[DATA_W-1] ? (DATA_W'(0) - div_rem) : div_rem;

	// execute step
	always_comb begin
		flag_n   = flag_q;
		remr_n   = remr_q;
		top_n    = top_q;
		pc_n     = pc_q;
		cnt_n    = cnt_q;
		wen      = 1'b0;
		wval     = '0;
		step     = 1'b1;
		take     = 1'b0;
		printed  = 1'b0;
		res_pv   = '0;
		err      = E_NONE;
		stk_we   = 1'b0;
		stk_wval = '0;
		case (op_t'(func_q))
			OP_MOV: begin wen = 1'b1; wval = b_q; end
			OP_PUSH, OP_PUSHF, OP_CALL: begin
				if (cnt_q == CNT_W'(STACK_DEPTH)) begin
					err = E_OVER; step = 1'b0;
				end else begin
					stk_we   = 1'b1;
					stk_wval = (func_q == OP_PUSH) ? a_q :
						(func_q == OP_PUSHF) ? flag_q : pc_q;
					cnt_n    = cnt_q + CNT_W'(1);
				end
			end
			OP_POP, OP_RET: begin
				step = 1'b0;
				if (cnt_q == '0) begin
					err = E_UNDER;
				end else begin
					cnt_n = cnt_q - CNT_W'(1);
					if (func_q == OP_POP) begin
						wen = 1'b1; wval = stk_s1;
					end
				end
			end
			OP_POPF: begin wen = 1'b1; wval = flag_q; step = 1'b0; end
			OP_INC: begin wen = 1'b1; wval = a_q + DATA_W'(1); end
			OP_DEC: begin wen = 1'b1; wval = a_q - DATA_W'(1); end
			OP_ADD: begin wen = 1'b1; wval = a_q + b_q; end
			OP_SUB: begin wen = 1'b1; wval = a_q - b_q; end
			OP_MUL: begin wen = 1'b1; wval = a_q * b_q; end
			OP_DIV: begin
				if (b_q == '0) begin err = E_DIV0; step = 1'b0; end
				else begin wen = 1'b1; wval = qs; end
			end
			OP_MOD: begin
				if (b_q == '0) begin err = E_DIV0; step = 1'b0; end
			end
			OP_REM: begin wen = 1'b1; wval = remr_q; end
			OP_NOT: begin wen = 1'b1; wval = ~a_q; end
			OP_OR:  begin wen = 1'b1; wval = a_q | b_q; end
			OP_AND: begin wen = 1'b1; wval = a_q & b_q; end
			OP_XOR: begin wen = 1'b1; wval = a_q ^ b_q; end
			OP_SHL: begin wen = 1'b1; wval = a_q << b_q[4:0]; end
			OP_SHR: begin wen = 1'b1; wval = DATA_W'($signed(a_q) >>> b_q[4:0]); end
			OP_JMP: take = 1'b1;
			OP_JE:  take = (flag_q == '0);
			OP_JNE: take = (flag_q != '0);
			OP_JG:  take = (flag_q != '0) && !flag_q[DATA_W-1];
			OP_JGE: take = !flag_q[DATA_W-1];
			OP_JL:  take = flag_q[DATA_W-1];
			OP_JLE: take = (flag_q == '0) || flag_q[DATA_W-1];
			OP_PRN: begin printed = 1'b1; res_pv = a_q; end
			default: ;
		endcase

		if (wen && dk_q == K_REG) begin
			if (di_q == R_FLAG)     flag_n = wval;
			else if (di_q == R_REM) remr_n = wval;
			else if (di_q == R_TOP) top_n = wval;
			else if (di_q == R_PC)  pc_n = wval;
		end

		case (op_t'(func_q))
			OP_PUSH, OP_PUSHF, OP_CALL: begin
				if (stk_we) begin
					top_n = DATA_W'(cnt_q);
					if (func_q == OP_CALL) begin
						pc_n = DATA_W'(tgt_q); step = 1'b0;
					end
				end
			end
			OP_POP, OP_RET: begin
				if (err == E_NONE) begin
					if (func_q == OP_POP) pc_n = pc_n + DATA_W'(1);
					else pc_n = stk_s1 + DATA_W'(1);
					top_n = DATA_W'(cnt_q) - DATA_W'(2);
				end
			end
			OP_POPF: begin
				if (dk_q != K_REG) top_n = DATA_W'(cnt_q) - DATA_W'(1);
				pc_n   = pc_n + DATA_W'(1);
				flag_n = '0;
			end
			OP_MOD: if (err == E_NONE) remr_n = rs;
			OP_REM: remr_n = '0;
			OP_CMP: flag_n = ($signed(b_q) < $signed(a_q)) ? DATA_W'(1) :
				(a_q == b_q) ? '0 : '1;
			default: ;
		endcase

		if (take) pc_n = DATA_W'(tgt_q);
		else if (step) pc_n = pc_n + DATA_W'(1);
	end

	// sequencer, architectural registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			flag_q   <= '0;
			remr_q   <= '0;
			top_q    <= '0;
			pc_q     <= '0;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
			func_q   <= '0;
			dk_q     <= '0;
			sk_q     <= '0;
			di_q     <= '0;
			si_q     <= '0;
			dimm_q   <= '0;
			simm_q   <= '0;
			tgt_q    <= '0;
			a_q      <= '0;
			b_q      <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_EXEC) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						func_q  <= in_func;
						dk_q    <= s_tdata[6:5];
						di_q    <= in_di;
						dimm_q  <= s_tdata[46:15];
						sk_q    <= s_tdata[48:47];
						si_q    <= in_si;
						simm_q  <= s_tdata[88:57];
						tgt_q   <= s_tdata[100:89];
						state_q <= ST_OPND;
					end
				end
				ST_OPND: begin
					a_q     <= a_c;
					b_q     <= b_c;
					state_q <= div_start ? ST_DIV : ST_EXEC;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free) begin
						flag_q   <= flag_n;
						remr_q   <= remr_n;
						top_q    <= top_n;
						pc_q     <= pc_n;
						cnt_q    <= cnt_n;
						m_tvalid <= 1'b1;
						m_tdata  <= {6'b0, err, res_pv, pc_n};
						m_tuser  <= printed;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic exec_go, gen_we, dm_we;
	assign exec_go = (state_q == ST_EXEC) && out_free;
	assign gen_we  = exec_go && wen && dk_q == K_REG && di_q < IDX_W'(REG_COUNT) &&
		di_q != R_FLAG && di_q != R_REM && di_q != R_TOP && di_q != R_PC;
	assign dm_we   = exec_go && wen && dk_q == K_MEM;

	// register file, data memory and stack storage
	always_ff @(posedge clk) begin
		if (gen_we) rf_mem[di_q[REG_AW-1:0]] <= wval;
		if (dm_we) dm_mem[di_q[MEM_AW-1:0]] <= wval;
		if (exec_go && stk_we) stk_mem[cnt_q[STK_AW-1:0]] <= stk_wval;
		if (acc) begin
			rfa_s1 <= rf_mem[in_di[REG_AW-1:0]];
			rfb_s1 <= rf_mem[in_si[REG_AW-1:0]];
			dma_s1 <= dm_mem[in_di[MEM_AW-1:0]];
			dmb_s1 <= dm_mem[in_si[MEM_AW-1:0]];
			stk_s1 <= stk_mem[STK_AW'(cnt_q - CNT_W'(1))];
			rfa_v_s1 <= rf_vld_q[in_di[REG_AW-1:0]] && in_di < IDX_W'(REG_COUNT);
			rfb_v_s1 <= rf_vld_q[in_si[REG_AW-1:0]] && in_si < IDX_W'(REG_COUNT);
			dma_v_s1 <= dm_vld_q[in_di[MEM_AW-1:0]];
			dmb_v_s1 <= dm_vld_q[in_si[MEM_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) rf_vld_q[i] <= 1'b0;
			for (int i = 0; i < MEM_WORDS; i++) dm_vld_q[i] <= 1'b0;
		end else begin
			if (gen_we) rf_vld_q[di_q[REG_AW-1:0]] <= 1'b1;
			if (dm_we) dm_vld_q[di_q[MEM_AW-1:0]] <= 1'b1;
		end
	end

	`SRVM_ASSERT_NXT(a_busy_after_acc, acc, !s_tready)
	`SRVM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH))
	`SRVM_ASSERT_NXT(a_cnt_only_exec, !exec_go, $stable(cnt_q) && $stable(pc_q))
	`SRVM_ASSERT_IMP(a_div_only_opnd, div_start, state_q == ST_OPND)
endmodule
`default_nettype wire

/* hw/rtl/srvm_div.sv */
// ----------------------------------------------------------------------------
// srvm_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module srvm_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [srvm_pkg::DATA_W-1:0] dividend,
	input  wire logic [srvm_pkg::DATA_W-1:0] divisor,
	output logic                           done,
	output logic [srvm_pkg::DATA_W-1:0]    quot,
	output logic [srvm_pkg::DATA_W-1:0]    rem
);
	import srvm_pkg::*;

	localparam int CW = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] quo_q, rem_q, dsr_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [DATA_W:0]   diff;

	assign diff = {rem_q, quo_q[DATA_W-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_W);
				quo_q  <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				if (diff[DATA_W]) begin
					rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				end else begin
					rem_q <= diff[DATA_W-1:0];
				end
				quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire
